// File: hdl/sprite_keyframe_sequencer_assert.svh
// Assertion macros for the sprite keyframe sequencer.
// Used by the top level only; no other dependencies.
`ifndef SPRITE_KEYFRAME_SEQUENCER_ASSERT_SVH
`define SPRITE_KEYFRAME_SEQUENCER_ASSERT_SVH

// Invariant that holds at every clock edge outside reset.
`define SKS_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("sprite sequencer: invariant violated");

// Same-cycle implication.
`define SKS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sprite sequencer: implication violated");

// Next-cycle implication.
`define SKS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sprite sequencer: next-cycle implication violated");

`endif

// File: hdl/sks_pkg.sv
// Package for the sprite keyframe sequencer: word types, sizes,
// microcode operations, conditions and the control program.
package sks_pkg;

   localparam int MAX_FRAMES = 16;
   localparam int COORD_BITS = 16;

   localparam int IDX_W  = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int CNT_W  = $clog2(MAX_FRAMES + 1);
   localparam int END_W  = 31;
   localparam int ELAP_W = 32;
   localparam int TICK_W = 16;
   localparam int T_W    = ELAP_W + 1;   // elapsed plus one tick
   localparam int REM_W  = END_W + 1;    // partial remainder before subtract
   localparam int MCNT_W = $clog2(T_W + 1);
   localparam int STEP_W = 5;

   typedef enum logic [1:0] {
      MODE_APPEND  = 2'd0,
      MODE_TICK    = 2'd1,
      MODE_RESTART = 2'd2,
      MODE_CLEAR   = 2'd3
   } mode_type;

   typedef logic [COORD_BITS-1:0] coord_type;

   typedef struct packed {
      coord_type u_from;
      coord_type v_from;
      coord_type u_to;
      coord_type v_to;
   } rect_type;

   typedef struct packed {
      mode_type          mode;
      logic [TICK_W-1:0] tick_time;
      logic [END_W-1:0]  new_end_time;
      logic [15:0]       new_u_from;
      logic [15:0]       new_v_from;
      logic [15:0]       new_u_to;
      logic [15:0]       new_v_to;
   } req_type;

   typedef struct packed {
      logic [3:0]  frame_index;
      logic        frame_changed;
      logic [15:0] u_from;
      logic [15:0] v_from;
      logic [15:0] u_to;
      logic [15:0] v_to;
      logic        append_rejected;
      logic        table_empty;
   } rsp_type;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_APPEND,
      OP_RESTART,
      OP_CLEAR,
      OP_TICK_INIT,
      OP_WALK,
      OP_WRAP,
      OP_MOD_INIT,
      OP_MOD_STEP,
      OP_MOD_FIX,
      OP_WRAP_FIX,
      OP_COMMIT,
      OP_PRESENT
   } op_type;

   typedef enum logic [3:0] {
      COND_NEXT,
      COND_ALWAYS,
      COND_DISPATCH,
      COND_EMPTY,
      COND_PASS,
      COND_FOUND,
      COND_LE_TOP,
      COND_MOD_BUSY,
      COND_RSP_BUSY
   } cond_type;

   typedef logic [STEP_W-1:0] step_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type target;
   } ctrl_word_type;

   localparam step_type STEP_IDLE     = 5'd0;
   localparam step_type STEP_APPEND   = 5'd1;
   localparam step_type STEP_RESTART  = 5'd2;
   localparam step_type STEP_CLEAR    = 5'd3;
   localparam step_type STEP_T_INIT   = 5'd4;
   localparam step_type STEP_W1_RD    = 5'd5;
   localparam step_type STEP_W1_CMP   = 5'd6;
   localparam step_type STEP_W1_END   = 5'd7;
   localparam step_type STEP_WRAP     = 5'd8;
   localparam step_type STEP_MOD_INIT = 5'd9;
   localparam step_type STEP_MOD_STEP = 5'd10;
   localparam step_type STEP_MOD_FIX  = 5'd11;
   localparam step_type STEP_W2_RD    = 5'd12;
   localparam step_type STEP_W2_CMP   = 5'd13;
   localparam step_type STEP_W2_END   = 5'd14;
   localparam step_type STEP_COMMIT   = 5'd15;
   localparam step_type STEP_FETCH    = 5'd16;
   localparam step_type STEP_OUT      = 5'd17;

   function automatic ctrl_word_type uc_word(op_type op, cond_type cond, step_type target);
      ctrl_word_type w;
      w.op     = op;
      w.cond   = cond;
      w.target = target;
      return w;
   endfunction

   // Control program: one word per step.
   function automatic ctrl_word_type uc_rom(step_type step);
      ctrl_word_type w;
      case (step)
         STEP_IDLE:     w = uc_word(OP_NOP,       COND_DISPATCH, STEP_IDLE);
         STEP_APPEND:   w = uc_word(OP_APPEND,    COND_ALWAYS,   STEP_FETCH);
         STEP_RESTART:  w = uc_word(OP_RESTART,   COND_ALWAYS,   STEP_FETCH);
         STEP_CLEAR:    w = uc_word(OP_CLEAR,     COND_ALWAYS,   STEP_FETCH);
         STEP_T_INIT:   w = uc_word(OP_TICK_INIT, COND_EMPTY,    STEP_FETCH);
         STEP_W1_RD:    w = uc_word(OP_NOP,       COND_NEXT,     STEP_IDLE);
         STEP_W1_CMP:   w = uc_word(OP_WALK,      COND_PASS,     STEP_W1_RD);
         STEP_W1_END:   w = uc_word(OP_NOP,       COND_FOUND,    STEP_COMMIT);
         STEP_WRAP:     w = uc_word(OP_WRAP,      COND_NEXT,     STEP_IDLE);
         STEP_MOD_INIT: w = uc_word(OP_MOD_INIT,  COND_LE_TOP,   STEP_W2_RD);
         STEP_MOD_STEP: w = uc_word(OP_MOD_STEP,  COND_MOD_BUSY, STEP_MOD_STEP);
         STEP_MOD_FIX:  w = uc_word(OP_MOD_FIX,   COND_NEXT,     STEP_IDLE);
         STEP_W2_RD:    w = uc_word(OP_NOP,       COND_NEXT,     STEP_IDLE);
         STEP_W2_CMP:   w = uc_word(OP_WALK,      COND_PASS,     STEP_W2_RD);
         STEP_W2_END:   w = uc_word(OP_WRAP_FIX,  COND_NEXT,     STEP_IDLE);
         STEP_COMMIT:   w = uc_word(OP_COMMIT,    COND_NEXT,     STEP_IDLE);
         STEP_FETCH:    w = uc_word(OP_NOP,       COND_NEXT,     STEP_IDLE);
         STEP_OUT:      w = uc_word(OP_PRESENT,   COND_RSP_BUSY, STEP_IDLE);
         default:       w = uc_word(OP_NOP,       COND_ALWAYS,   STEP_IDLE);
      endcase
      return w;
   endfunction

   // First step of the routine for each mode.
   function automatic step_type entry_step(mode_type mode);
      step_type s;
      case (mode)
         MODE_APPEND:  s = STEP_APPEND;
         MODE_TICK:    s = STEP_T_INIT;
         MODE_RESTART: s = STEP_RESTART;
         MODE_CLEAR:   s = STEP_CLEAR;
         default:      s = STEP_IDLE;
      endcase
      return s;
   endfunction

endpackage

// File: hdl/sprite_keyframe_sequencer.sv
// Sprite keyframe sequencer: frame table, microcoded control and datapath.
// Depends on sks_pkg and sprite_keyframe_sequencer_assert.svh.
//
// Usage: each word on the req channel is one command (append frame, tick,
// restart, clear); each produces exactly one word on the rsp channel that
// describes the current frame and its texture rectangle.
// Channels are valid/ready. req_ready is high only while the sequencer sits
// at its idle step; one command is worked on at a time. The result waits in
// an output register, so the next command is taken while it is unread.
// Append, restart, clear and a tick on an empty table do no table walk.
// A tick walks the table from the current frame, a table read and then
// a compare for each frame stepped. A tick past the last frame walks
// again from frame 0; when the time still exceeds the latest end time
// after one loop, a bit-serial remainder by the loop length comes first.
// Reset (synchronous, active high) empties the table and zeroes time and
// frame; frame data is written only by append and needs no clearing.
// If rsp is stalled when a result is ready, the sequencer holds at its
// output step until the previous word is taken.
module sprite_keyframe_sequencer (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  sks_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output sks_pkg::rsp_type rsp_data
);
   import sks_pkg::*;

   `include "sprite_keyframe_sequencer_assert.svh"

   // frame table
   logic [END_W-1:0] end_mem [MAX_FRAMES];
   rect_type         rect_mem [MAX_FRAMES];
   logic [END_W-1:0] end_rd_ff;
   rect_type         rect_rd_ff;
   logic             mem_we;
   rect_type         new_rect;

   // sequencer
   step_type      step_ff, step_in;
   ctrl_word_type cw;

   // architectural state
   logic [CNT_W-1:0]  loaded_ff, loaded_in;
   logic [END_W-1:0]  loop_ff, loop_in;
   logic [END_W-1:0]  top_ff, top_in;
   logic [ELAP_W-1:0] elapsed_ff, elapsed_in;
   logic [IDX_W-1:0]  cur_ff, cur_in;

   // scratch
   req_type           item_ff, item_in;
   logic [T_W-1:0]    t_ff, t_in;
   logic [CNT_W-1:0]  k_ff, k_in;
   logic [T_W-1:0]    d_ff, d_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [MCNT_W-1:0] mcnt_ff, mcnt_in;
   logic              changed_ff, changed_in;
   logic              rejected_ff, rejected_in;

   // output register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic             req_accept;
   logic             rsp_busy;
   logic             walk_pass;
   logic             k_found;
   logic             table_full;
   logic [REM_W-1:0] rem_shift;

   assign req_ready  = (step_ff == STEP_IDLE);
   assign req_accept = req_valid && req_ready;
   assign rsp_busy   = rsp_valid_ff && !rsp_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   assign cw         = uc_rom(step_ff);
   assign k_found    = (k_ff < loaded_ff);
   assign walk_pass  = k_found && (t_ff > T_W'(end_rd_ff));
   assign table_full = (loaded_ff >= CNT_W'(MAX_FRAMES));
   assign rem_shift  = {rem_ff[REM_W-2:0], d_ff[T_W-1]};

   assign new_rect.u_from = COORD_BITS'(item_ff.new_u_from);
   assign new_rect.v_from = COORD_BITS'(item_ff.new_v_from);
   assign new_rect.u_to   = COORD_BITS'(item_ff.new_u_to);
   assign new_rect.v_to   = COORD_BITS'(item_ff.new_v_to);

   // next step
   always_comb begin
      step_in = step_ff + step_type'(1);
      case (cw.cond)
         COND_NEXT:     step_in = step_ff + step_type'(1);
         COND_ALWAYS:   step_in = cw.target;
         COND_DISPATCH: step_in = req_accept ? entry_step(req_data.mode) : step_ff;
         COND_EMPTY: begin
            if (loaded_ff == '0) step_in = cw.target;
         end
         COND_PASS: begin
            if (walk_pass) step_in = cw.target;
         end
         COND_FOUND: begin
            if (k_found) step_in = cw.target;
         end
         COND_LE_TOP: begin
            if (t_ff <= T_W'(top_ff)) step_in = cw.target;
         end
         COND_MOD_BUSY: begin
            if (mcnt_ff != MCNT_W'(1)) step_in = cw.target;
         end
         COND_RSP_BUSY: step_in = rsp_busy ? step_ff : cw.target;
         default:       step_in = STEP_IDLE;
      endcase
   end

   // datapath controls
   always_comb begin
      item_in      = req_accept ? req_data : item_ff;
      loaded_in    = loaded_ff;
      loop_in      = loop_ff;
      top_in       = top_ff;
      elapsed_in   = elapsed_ff;
      cur_in       = cur_ff;
      t_in         = t_ff;
      k_in         = k_ff;
      d_in         = d_ff;
      rem_in       = rem_ff;
      mcnt_in      = mcnt_ff;
      changed_in   = changed_ff;
      rejected_in  = rejected_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      mem_we       = 1'b0;
      case (cw.op)
         OP_NOP: begin
         end
         OP_APPEND: begin
            changed_in  = 1'b0;
            rejected_in = table_full;
            if (!table_full) begin
               mem_we    = 1'b1;
               loaded_in = loaded_ff + CNT_W'(1);
               loop_in   = item_ff.new_end_time;
               if (item_ff.new_end_time > top_ff) top_in = item_ff.new_end_time;
            end
         end
         OP_RESTART: begin
            cur_in      = '0;
            elapsed_in  = '0;
            changed_in  = (loaded_ff != '0);
            rejected_in = 1'b0;
         end
         OP_CLEAR: begin
            loaded_in   = '0;
            loop_in     = '0;
            top_in      = '0;
            elapsed_in  = '0;
            cur_in      = '0;
            changed_in  = 1'b0;
            rejected_in = 1'b0;
         end
         OP_TICK_INIT: begin
            t_in        = T_W'(elapsed_ff) + T_W'(item_ff.tick_time);
            k_in        = CNT_W'(cur_ff);
            changed_in  = 1'b0;
            rejected_in = 1'b0;
         end
         OP_WALK: begin
            if (walk_pass) k_in = k_ff + CNT_W'(1);
         end
         OP_WRAP: begin
            t_in = (loop_ff == '0) ? '0 : t_ff - T_W'(loop_ff);
            k_in = '0;
         end
         OP_MOD_INIT: begin
            d_in    = t_ff - T_W'(top_ff);
            rem_in  = '0;
            mcnt_in = MCNT_W'(T_W);
         end
         OP_MOD_STEP: begin
            // restoring remainder, one bit of the excess per step
            rem_in  = (rem_shift >= REM_W'(loop_ff)) ? rem_shift - REM_W'(loop_ff)
                                                     : rem_shift;
            d_in    = {d_ff[T_W-2:0], 1'b0};
            mcnt_in = mcnt_ff - MCNT_W'(1);
         end
         OP_MOD_FIX: begin
            // drop whole loops until the time is back at or below the top end
            t_in = (rem_ff == '0) ? T_W'(top_ff)
                                  : T_W'(top_ff) + T_W'(rem_ff) - T_W'(loop_ff);
         end
         OP_WRAP_FIX: begin
            if (!k_found) k_in = '0;
         end
         OP_COMMIT: begin
            elapsed_in = t_ff[ELAP_W-1:0];
            cur_in     = k_ff[IDX_W-1:0];
            changed_in = (k_ff[IDX_W-1:0] != cur_ff);
         end
         OP_PRESENT: begin
            if (!rsp_busy) begin
               rsp_valid_in           = 1'b1;
               rsp_in.frame_index     = 4'(cur_ff);
               rsp_in.frame_changed   = changed_ff;
               rsp_in.append_rejected = rejected_ff;
               rsp_in.table_empty     = (loaded_ff == '0);
               if (loaded_ff != '0) begin
                  rsp_in.u_from = 16'(rect_rd_ff.u_from);
                  rsp_in.v_from = 16'(rect_rd_ff.v_from);
                  rsp_in.u_to   = 16'(rect_rd_ff.u_to);
                  rsp_in.v_to   = 16'(rect_rd_ff.v_to);
               end else begin
                  rsp_in.u_from = '0;
                  rsp_in.v_from = '0;
                  rsp_in.u_to   = '0;
                  rsp_in.v_to   = '0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // frame table write and registered reads
   always_ff @(posedge clock) begin
      if (mem_we) begin
         end_mem[loaded_ff[IDX_W-1:0]]  <= item_ff.new_end_time;
         rect_mem[loaded_ff[IDX_W-1:0]] <= new_rect;
      end
   end

   always_ff @(posedge clock) begin
      end_rd_ff  <= end_mem[k_ff[IDX_W-1:0]];
      rect_rd_ff <= rect_mem[cur_ff];
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= STEP_IDLE;
         loaded_ff    <= '0;
         loop_ff      <= '0;
         top_ff       <= '0;
         elapsed_ff   <= '0;
         cur_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         loaded_ff    <= loaded_in;
         loop_ff      <= loop_in;
         top_ff       <= top_in;
         elapsed_ff   <= elapsed_in;
         cur_ff       <= cur_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // scratch and payload
   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      t_ff        <= t_in;
      k_ff        <= k_in;
      d_ff        <= d_in;
      rem_ff      <= rem_in;
      mcnt_ff     <= mcnt_in;
      changed_ff  <= changed_in;
      rejected_ff <= rejected_in;
      rsp_ff      <= rsp_in;
   end

   `SKS_ASSERT_ALWAYS(a_loaded_bound, clock, reset, loaded_ff <= CNT_W'(MAX_FRAMES))
   `SKS_ASSERT_IMPLY(a_cur_in_table, clock, reset, loaded_ff != '0, CNT_W'(cur_ff) < loaded_ff)
   `SKS_ASSERT_ALWAYS(a_time_in_loop, clock, reset, elapsed_ff <= ELAP_W'(top_ff))
   `SKS_ASSERT_IMPLY(a_rem_bound, clock, reset, step_ff == STEP_MOD_STEP, rem_ff < REM_W'(loop_ff))
   `SKS_ASSERT_NEXT(a_present, clock, reset, (step_ff == STEP_OUT) && !rsp_busy, rsp_valid_ff)

endmodule

// File: dv/testbench.sv
// Self-checking testbench for the sprite keyframe sequencer: queue-fed driver,
// clocked monitor and a cycle-free model of the frame walk.
// Depends on sks_pkg and the sprite_keyframe_sequencer RTL.
`timescale 1ns / 1ps

module testbench;
   import sks_pkg::*;

   localparam int RESET_CYCLES = 7;
   localparam int TAIL_WORDS   = 100;
   localparam int RANDOM_WORDS = 800;
   localparam int STALL_LIMIT  = 4000;
   localparam int DRAIN_CYCLES = 200;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   req_type pending_words[$];
   rsp_type expected_rsp[$];
   int      words_sent    = 0;
   int      mismatches    = 0;
   int      req_gap       = 0;
   int      rsp_hold      = 0;
   bit      backlog_done  = 1'b0;
   int      quiet_cycles  = 0;

   // Model state: frame table, loop length, time and current frame.
   logic [END_W-1:0]  seq_end [MAX_FRAMES];
   rect_type          seq_rect [MAX_FRAMES];
   int unsigned       seq_count   = 0;
   logic [END_W-1:0]  seq_loop    = '0;
   logic [ELAP_W-1:0] seq_elapsed = '0;
   logic [IDX_W-1:0]  seq_frame   = '0;

   sprite_keyframe_sequencer u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int unsigned first_unpassed(int unsigned from, longint unsigned t);
      int unsigned k;
      k = from;
      while (k < seq_count && t > seq_end[k]) k++;
      return k;
   endfunction

   function automatic rsp_type advance_sequencer(req_type w);
      rsp_type          r;
      logic [IDX_W-1:0] prior;
      longint unsigned  t;
      longint unsigned  top;
      longint unsigned  laps;
      int unsigned      f;
      int unsigned      k;
      r = '0;
      prior = seq_frame;
      case (w.mode)
         MODE_APPEND: begin
            if (seq_count >= MAX_FRAMES) begin
               r.append_rejected = 1'b1;
            end else begin
               seq_end[seq_count]  = w.new_end_time;
               seq_rect[seq_count] = {w.new_u_from, w.new_v_from, w.new_u_to, w.new_v_to};
               seq_loop = w.new_end_time;
               seq_count++;
            end
         end
         MODE_TICK: begin
            if (seq_count != 0) begin
               t = seq_elapsed + w.tick_time;
               f = first_unpassed(seq_frame, t);
               if (f >= seq_count) begin
                  if (seq_loop == 0) begin
                     t = 0;
                  end else begin
                     t -= seq_loop;
                     top = 0;
                     for (k = 0; k < seq_count; k++)
                        if (seq_end[k] > top) top = seq_end[k];
                     // drop whole loops that still lie beyond the latest end time
                     if (t > top) begin
                        laps = (t - top + seq_loop - 1) / seq_loop;
                        t -= laps * seq_loop;
                     end
                  end
                  f = first_unpassed(0, t);
                  if (f >= seq_count) f = 0;
               end
               seq_elapsed = t[ELAP_W-1:0];
               seq_frame   = f[IDX_W-1:0];
               r.frame_changed = (seq_frame != prior);
            end
         end
         MODE_RESTART: begin
            seq_frame   = '0;
            seq_elapsed = '0;
            r.frame_changed = (seq_count != 0);
         end
         MODE_CLEAR: begin
            seq_count   = 0;
            seq_loop    = '0;
            seq_elapsed = '0;
            seq_frame   = '0;
         end
      endcase
      r.frame_index = seq_frame;
      if (seq_count != 0) begin
         r.u_from = seq_rect[seq_frame].u_from;
         r.v_from = seq_rect[seq_frame].v_from;
         r.u_to   = seq_rect[seq_frame].u_to;
         r.v_to   = seq_rect[seq_frame].v_to;
      end
      r.table_empty = (seq_count == 0);
      return r;
   endfunction

   // Fields that the mode does not use carry random bits.
   function automatic req_type make_word(mode_type m);
      req_type w;
      w.mode         = m;
      w.tick_time    = 16'($urandom);
      w.new_end_time = 31'($urandom);
      w.new_u_from   = 16'($urandom);
      w.new_v_from   = 16'($urandom);
      w.new_u_to     = 16'($urandom);
      w.new_v_to     = 16'($urandom);
      return w;
   endfunction

   function automatic req_type make_append(logic [END_W-1:0] end_t, rect_type rect);
      req_type w;
      w = make_word(MODE_APPEND);
      w.new_end_time = end_t;
      w.new_u_from   = rect.u_from;
      w.new_v_from   = rect.v_from;
      w.new_u_to     = rect.u_to;
      w.new_v_to     = rect.v_to;
      return w;
   endfunction

   function automatic req_type make_tick(logic [TICK_W-1:0] dt);
      req_type w;
      w = make_word(MODE_TICK);
      w.tick_time = dt;
      return w;
   endfunction

   function automatic rect_type random_rect();
      return rect_type'({$urandom, $urandom});
   endfunction

   // Append a word to the tail of the pending queue.
   function automatic void queue_word(req_type w);
      pending_words.insert(pending_words.size(), w);
   endfunction

   // Idle in two of every three windows of 64 words, never in the tail of the run.
   function automatic bit idle_ok();
      return pending_words.size() >= TAIL_WORDS && (words_sent / 64) % 3 != 2;
   endfunction

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   // Driver: hold the word until accepted, then offer the next or idle.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_rsp.insert(expected_rsp.size(), advance_sequencer(req_data));
            words_sent <= words_sent + 1;
         end
         if (!req_valid || req_ready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (idle_ok() && $urandom_range(0, 4) == 0) begin
               req_gap = $urandom_range(0, 3);
               req_valid <= 1'b0;
            end else if (pending_words.size() != 0) begin
               req_data  <= pending_words.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compare each result word with the oldest expectation.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp.size() == 0) begin
               $error("result word with nothing expected");
               mismatches++;
            end else begin
               want = expected_rsp.pop_front();
               check_field("frame_index", want.frame_index, rsp_data.frame_index);
               check_field("frame_changed", want.frame_changed, rsp_data.frame_changed);
               check_field("u_from", want.u_from, rsp_data.u_from);
               check_field("v_from", want.v_from, rsp_data.v_from);
               check_field("u_to", want.u_to, rsp_data.u_to);
               check_field("v_to", want.v_to, rsp_data.v_to);
               check_field("append_rejected", want.append_rejected, rsp_data.append_rejected);
               check_field("table_empty", want.table_empty, rsp_data.table_empty);
            end
         end
         // hold off once for a long stretch so the block backs up into req
         if (!backlog_done && words_sent >= 300) begin
            backlog_done = 1'b1;
            rsp_hold = 250;
         end
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_ready <= 1'b0;
         end else if (idle_ok() && $urandom_range(0, 4) == 0) begin
            rsp_hold = $urandom_range(0, 3);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   initial begin
      int               k;
      int               random_items;
      int               frames;
      bit               wild;
      logic [END_W-1:0] end_t;

      // Empty table: tick, restart and clear.
      queue_word(make_tick(16'hFFFF));
      queue_word(make_word(MODE_RESTART));
      queue_word(make_word(MODE_CLEAR));
      // Zero loop length: the wrap clears the time and stays on frame 0.
      queue_word(make_append(31'd0, '0));
      queue_word(make_tick(16'd5));
      queue_word(make_word(MODE_CLEAR));
      // Fill the table, the last frame at the largest end time, then overflow.
      for (k = 0; k < MAX_FRAMES - 1; k++)
         queue_word(make_append(31'(10 * (k + 1)), random_rect()));
      queue_word(make_append(31'h7FFF_FFFF, '1));
      queue_word(make_append(31'd1, random_rect()));
      queue_word(make_tick(16'hFFFF));
      queue_word(make_word(MODE_RESTART));
      queue_word(make_word(MODE_CLEAR));
      // Short loop: one tick wraps many times.
      queue_word(make_append(31'd3, random_rect()));
      queue_word(make_append(31'd7, random_rect()));
      queue_word(make_tick(16'hFFFF));

      random_items = 0;
      while (random_items < RANDOM_WORDS) begin
         if ($urandom_range(0, 7) != 0) begin
            queue_word(make_word(MODE_CLEAR));
            random_items++;
         end
         frames = ($urandom_range(0, 3) == 0) ? $urandom_range(1, MAX_FRAMES)
                                              : $urandom_range(1, 5);
         wild   = ($urandom_range(0, 5) == 0);
         end_t  = 31'($urandom_range(0, 20));
         repeat (frames) begin
            if (wild)
               end_t = 31'($urandom);
            else
               end_t = end_t + 31'($urandom_range(0, 100));
            queue_word(make_append(end_t, random_rect()));
            random_items++;
         end
         repeat ($urandom_range(4, 30)) begin
            case ($urandom_range(0, 15))
               0:       queue_word(make_word(MODE_RESTART));
               1:       queue_word(make_append(end_t + 31'($urandom_range(0, 50)),
                                               random_rect()));
               2:       queue_word(make_word(MODE_CLEAR));
               3, 4:    queue_word(make_tick(16'($urandom)));
               5, 6, 7: queue_word(make_tick(16'($urandom_range(0, 1000))));
               default: queue_word(make_tick(16'($urandom_range(0, 60))));
            endcase
            random_items++;
         end
      end

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      while (pending_words.size() != 0 || req_valid || expected_rsp.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

// File: sim.f
+incdir+hdl
hdl/sks_pkg.sv
hdl/sprite_keyframe_sequencer.sv
dv/testbench.sv
